// ===== rtl/core/quad_prescaled_timer_bank_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef QUAD_PRESCALED_TIMER_BANK_MACROS_SVH
`define QUAD_PRESCALED_TIMER_BANK_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define QPT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/qpt_pkg.sv =====
`default_nettype none

package qpt_pkg;

   localparam int TIMER_SLOTS = 4;
   localparam int COUNT_W     = 16;
   localparam int PRESCALE_W  = 11;
   localparam int SEL_W       = 2;
   localparam int OFFSET_W    = 4;

   localparam int CTRL_IRQ_BIT = 6;
   localparam int CTRL_RUN_BIT = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                command;
      logic [OFFSET_W-1:0]    reg_offset;
      logic [COUNT_W-1:0]     write_data;
   } req_item_type;

   typedef struct packed {
      logic                   bad_access;
      logic [TIMER_SLOTS-1:0] overflow_pulse;
      logic [COUNT_W-1:0]     read_data;
   } rsp_item_type;

   // Per-timer update strobes, already qualified by the pipeline step.
   typedef struct packed {
      logic tick;
      logic load_count;
      logic load_ctrl;
   } qpt_ctl_type;

   // Prescale divider for a select code: 1, 64, 256 or 1024.
   function automatic logic [PRESCALE_W-1:0] divider_value(input logic [SEL_W-1:0] sel);
      logic [PRESCALE_W-1:0] div;
      case (sel)
         2'd0:    div = 11'd1;
         2'd1:    div = 11'd64;
         2'd2:    div = 11'd256;
         2'd3:    div = 11'd1024;
         default: div = 11'd1;
      endcase
      return div;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/quad_prescaled_timer_bank.sv =====
// Channel  | Ports                       | Contents
// ---------+-----------------------------+-------------------------------------------
// request  | req_tvalid/tready/tdata/tuser | one tick, register read or register write
// response | rsp_tvalid/tready/tdata     | read data, overflow pulses, bad access flag
//
// One item per cycle sustained while the response side is ready; an accepted request
// passes through the input register, then the result register, to the response.
// Timer state updates in the same cycle the item moves into the result register.
// Synchronous active-high reset clears all timers and both pipeline valids.
// A stalled response holds the result register; the input register still takes
// one more item, then the request side stalls.
`default_nettype none

`include "quad_prescaled_timer_bank_macros.svh"

module quad_prescaled_timer_bank #(
   parameter int NUM_TIMERS = 4
) (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // [3:0] reg_offset, [19:4] write_data, [23:20] zero
   input  wire  [1:0]  req_tuser,   // [1:0] command

   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata    // [15:0] read_data, [19:16] overflow_pulse,
                                    // [20] bad_access, [23:21] zero
);
   import qpt_pkg::*;

   // Pipeline registers: input stage and result stage.
   logic          in_valid_ff,  in_valid_in;
   req_item_type  in_ff,        in_in;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_ff,       out_in;

   logic          req_take;
   logic          step;

   // Decode of the item held in the input register.
   logic [1:0]    timer_sel;
   logic          is_control;
   logic          addr_ok;

   logic [TIMER_SLOTS-1:0][COUNT_W-1:0] counts;
   logic [TIMER_SLOTS-1:0]              wraps;

   // Advance the input item into the result stage whenever the result slot frees.
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   assign in_in.command    = cmd_type'(req_tuser[1:0]);
   assign in_in.reg_offset = req_tdata[OFFSET_W-1:0];
   assign in_in.write_data = req_tdata[OFFSET_W +: COUNT_W];

   assign timer_sel  = in_ff.reg_offset[3:2];
   assign is_control = in_ff.reg_offset[1];
   // Odd offsets and timers past the populated count hit nothing.
   assign addr_ok    = !in_ff.reg_offset[0] && ({1'b0, timer_sel} < 3'(NUM_TIMERS));

   // One timer per populated slot; empty slots read as zero.
   for (genvar t = 0; t < TIMER_SLOTS; t++) begin : g_slot
      if (t < NUM_TIMERS) begin : g_timer
         qpt_ctl_type ctl;
         logic        hit_me;

         assign hit_me         = step && addr_ok && (timer_sel == 2'(t));
         assign ctl.tick       = step && (in_ff.command == CMD_TICK);
         assign ctl.load_count = hit_me && (in_ff.command == CMD_WRITE) && !is_control;
         assign ctl.load_ctrl  = hit_me && (in_ff.command == CMD_WRITE) && is_control;

         qpt_timer u_timer (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .write_data  (in_ff.write_data),
            .count_value (counts[t]),
            .wrap_pulse  (wraps[t])
         );
      end else begin : g_empty
         assign counts[t] = '0;
         assign wraps[t]  = 1'b0;
      end
   end

   // Build the response for the item in the input register.
   always_comb begin
      out_in.read_data      = '0;
      out_in.overflow_pulse = '0;
      out_in.bad_access     = 1'b0;
      case (in_ff.command)
         CMD_TICK: begin
            out_in.overflow_pulse = wraps;
         end
         CMD_READ: begin
            if (addr_ok && !is_control) begin
               out_in.read_data = counts[timer_sel];
            end else begin
               out_in.bad_access = 1'b1;
            end
         end
         CMD_WRITE: begin
            out_in.bad_access = !addr_ok;
         end
         default: begin
            // Unknown command: all-zero response, no state change.
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on accept or step, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= in_in;
      end
      if (step) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.bad_access, out_ff.overflow_pulse, out_ff.read_data};

   `QPT_ASSERT_SAME(a_bad_is_quiet, clock, reset, out_valid_ff && out_ff.bad_access, (out_ff.read_data == '0) && (out_ff.overflow_pulse == '0), "bad access carries data")
   `QPT_ASSERT_NEXT(a_pulse_only_tick, clock, reset, step && (in_ff.command != CMD_TICK), out_ff.overflow_pulse == '0, "overflow pulse outside a tick")
   `QPT_ASSERT_NEXT(a_data_only_read, clock, reset, step && (in_ff.command != CMD_READ), out_ff.read_data == '0, "read data outside a read")
   `QPT_ASSERT_NEXT(a_input_holds, clock, reset, in_valid_ff && !step, in_valid_ff && $stable(in_ff), "held input item changed")

endmodule

`default_nettype wire

// ===== rtl/core/qpt_timer.sv =====
`default_nettype none

module qpt_timer (
   input  wire                          clock,
   input  wire                          reset,
   input  qpt_pkg::qpt_ctl_type         ctl,
   input  wire  [qpt_pkg::COUNT_W-1:0]  write_data,
   output logic [qpt_pkg::COUNT_W-1:0]  count_value,
   output logic                         wrap_pulse
);
   import qpt_pkg::*;

   logic [COUNT_W-1:0]    count_ff,    count_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic [SEL_W-1:0]      sel_ff,      sel_in;
   logic                  irq_ff,      irq_in;
   logic                  run_ff,      run_in;

   logic [PRESCALE_W-1:0] prescale_inc;
   logic                  hit;

   assign prescale_inc = prescale_ff + 1'b1;
   assign hit          = run_ff && (prescale_inc >= divider_value(sel_ff));
   assign count_value  = count_ff;
   // Raised when the next tick would wrap the counter with the interrupt on.
   assign wrap_pulse   = hit && irq_ff && (count_ff == COUNT_MAX);

   always_comb begin
      count_in    = count_ff;
      prescale_in = prescale_ff;
      sel_in      = sel_ff;
      irq_in      = irq_ff;
      run_in      = run_ff;
      if (ctl.tick && run_ff) begin
         if (hit) begin
            prescale_in = '0;
            count_in    = count_ff + 1'b1;
         end else begin
            prescale_in = prescale_inc;
         end
      end
      if (ctl.load_count) begin
         count_in    = write_data;
         prescale_in = '0;
      end
      if (ctl.load_ctrl) begin
         prescale_in = '0;
         sel_in      = write_data[SEL_W-1:0];
         irq_in      = write_data[CTRL_IRQ_BIT];
         run_in      = write_data[CTRL_RUN_BIT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         prescale_ff <= '0;
         sel_ff      <= '0;
         irq_ff      <= 1'b0;
         run_ff      <= 1'b0;
      end else begin
         count_ff    <= count_in;
         prescale_ff <= prescale_in;
         sel_ff      <= sel_in;
         irq_ff      <= irq_in;
         run_ff      <= run_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Streaming testbench for the four-timer prescaled bank. A predictor in this
// file follows every accepted request item and keeps a queue of the response
// items it expects. The checker compares each accepted response with the
// oldest entry in that queue. Both sides of the block idle at random, and at
// one point the response side is held off long enough to fill the pipeline.
module testbench;
   import qpt_pkg::*;

   localparam int BANK_TIMERS  = 4;
   localparam int HOLD_CYCLES  = 40;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 24;
   localparam int MAX_REPORTS  = 10;

   // Divider select codes, bits 1:0 of a control word
   localparam logic [SEL_W-1:0] SEL_DIV1    = 2'd0;
   localparam logic [SEL_W-1:0] SEL_DIV64   = 2'd1;
   localparam logic [SEL_W-1:0] SEL_DIV256  = 2'd2;
   localparam logic [SEL_W-1:0] SEL_DIV1024 = 2'd3;

   localparam logic [PRESCALE_W-1:0] DIVIDE_BY [4] = '{11'd1, 11'd64, 11'd256, 11'd1024};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [3:0] reg_offset, [19:4] write_data, [23:20] zero
   logic [1:0]  req_tuser  = '0;   // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [15:0] read_data, [19:16] overflow_pulse,
                                   // [20] bad_access, [23:21] zero

   // Predicted timer state
   logic [COUNT_W-1:0]    model_count    [BANK_TIMERS];
   logic [PRESCALE_W-1:0] model_prescale [BANK_TIMERS];
   logic [SEL_W-1:0]      model_sel      [BANK_TIMERS];
   logic                  model_irq      [BANK_TIMERS];
   logic                  model_run      [BANK_TIMERS];

   rsp_item_type expected_timer_rsp [$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  hold_left      = 0;
   bit  hold_start     = 1'b0;
   bit  idle_enabled   = 1'b0;

   quad_prescaled_timer_bank #(
      .NUM_TIMERS (BANK_TIMERS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bound the run; a hang anywhere ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** quad_prescaled_timer_bank: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic logic [OFFSET_W-1:0] counter_offset(int t);
      return OFFSET_W'(t * 4);
   endfunction

   function automatic logic [OFFSET_W-1:0] control_offset(int t);
      return OFFSET_W'(t * 4 + 2);
   endfunction

   function automatic logic [COUNT_W-1:0] control_word(logic [SEL_W-1:0] sel, bit irq, bit run);
      logic [COUNT_W-1:0] w;
      w = '0;
      w[SEL_W-1:0]    = sel;
      w[CTRL_IRQ_BIT] = irq;
      w[CTRL_RUN_BIT] = run;
      return w;
   endfunction

   task automatic clear_timer_model();
      for (int t = 0; t < BANK_TIMERS; t++) begin
         model_count[t]    = '0;
         model_prescale[t] = '0;
         model_sel[t]      = SEL_DIV1;
         model_irq[t]      = 1'b0;
         model_run[t]      = 1'b0;
      end
   endtask

   // Apply one accepted item to the predicted state and queue its response
   task automatic predict_timer_bank(cmd_type cmd, logic [OFFSET_W-1:0] off,
                                     logic [COUNT_W-1:0] wd);
      rsp_item_type res;
      int           timer;
      bit           is_ctrl;
      bit           known;
      res     = '0;
      timer   = int'(off[3:2]);
      is_ctrl = off[1];
      known   = !off[0] && timer < BANK_TIMERS;
      case (cmd)
         CMD_TICK: begin
            for (int t = 0; t < BANK_TIMERS; t++) begin
               if (model_run[t]) begin
                  model_prescale[t] = model_prescale[t] + 1'b1;
                  if (model_prescale[t] >= DIVIDE_BY[model_sel[t]]) begin
                     model_prescale[t] = '0;
                     model_count[t]    = model_count[t] + 1'b1;
                     if (model_count[t] == '0 && model_irq[t])
                        res.overflow_pulse[t] = 1'b1;
                  end
               end
            end
         end
         CMD_READ: begin
            if (known && !is_ctrl)
               res.read_data = model_count[timer];
            else
               res.bad_access = 1'b1;
         end
         CMD_WRITE: begin
            if (!known) begin
               res.bad_access = 1'b1;
            end else if (is_ctrl) begin
               model_prescale[timer] = '0;
               model_sel[timer]      = wd[SEL_W-1:0];
               model_irq[timer]      = wd[CTRL_IRQ_BIT];
               model_run[timer]      = wd[CTRL_RUN_BIT];
            end else begin
               model_prescale[timer] = '0;
               model_count[timer]    = wd;
            end
         end
         default: ;   // unknown command: no effect, all-zero response
      endcase
      expected_timer_rsp.push_back(res);
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Drop valid so the last item is not offered twice, then change idling
   // away from the falling edge the drivers use
   task automatic set_idling(bit on);
      @(negedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
      idle_enabled = on;
   endtask

   // Offer one item, with random gaps ahead of it, and hold it until taken.
   // Valid stays high between back-to-back items.
   task automatic send_item(cmd_type cmd, logic [OFFSET_W-1:0] off, logic [COUNT_W-1:0] wd);
      @(negedge clock);
      while (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'd0, wd, off};
      do @(posedge clock); while (!req_tready);
      predict_timer_bank(cmd, off, wd);
   endtask

   // Mostly well-formed traffic: configure, load near the wrap, tick, read.
   // The rest is noise over the whole field space.
   task automatic send_random_item();
      int                 pick;
      int                 t;
      logic [COUNT_W-1:0] wd;
      pick = $urandom_range(99);
      t    = $urandom_range(BANK_TIMERS - 1);
      wd   = COUNT_W'($urandom);
      if (pick < 15) begin
         // favor divide by one and a running timer so wraps happen often
         if ($urandom_range(99) < 60) wd[SEL_W-1:0] = SEL_DIV1;
         if ($urandom_range(99) < 80) wd[CTRL_RUN_BIT] = 1'b1;
         send_item(CMD_WRITE, control_offset(t), wd);
      end else if (pick < 30) begin
         if ($urandom_range(1) == 1) wd = COUNT_MAX - COUNT_W'($urandom_range(6));
         send_item(CMD_WRITE, counter_offset(t), wd);
      end else if (pick < 70) begin
         send_item(CMD_TICK, OFFSET_W'($urandom), wd);
      end else if (pick < 85) begin
         send_item(CMD_READ, counter_offset(t), wd);
      end else begin
         send_item(cmd_type'($urandom_range(3)), OFFSET_W'($urandom), wd);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Stall at random; a requested hold-off keeps ready low until hold_left runs out
   always @(negedge clock) begin
      if (hold_start) begin
         hold_left  = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_enabled && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   function automatic void note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   function automatic void check_field(string name, logic [COUNT_W-1:0] want,
                                       logic [COUNT_W-1:0] got);
      if (got !== want)
         note_failure($sformatf("%s expected %h, got %h", name, want, got));
   endfunction

   // Compare every accepted response with the oldest expectation
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_timer_rsp.size() == 0) begin
            note_failure($sformatf("response with none expected, tdata=%h", rsp_tdata));
         end else begin
            want = expected_timer_rsp.pop_front();
            check_field("read_data", want.read_data, rsp_tdata[15:0]);
            check_field("overflow_pulse", COUNT_W'(want.overflow_pulse),
                        COUNT_W'(rsp_tdata[19:16]));
            check_field("bad_access", COUNT_W'(want.bad_access), COUNT_W'(rsp_tdata[20]));
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values, bad offsets, the unknown command, and wraps with and
   // without the interrupt enabled
   task automatic test_register_access();
      set_idling(1'b1);
      send_item(CMD_READ, counter_offset(0), 16'h0000);
      send_item(CMD_READ, counter_offset(3), 16'hFFFF);
      send_item(CMD_READ, control_offset(1), 16'h0000);   // control is write-only
      send_item(CMD_READ, 4'hF, 16'h0000);                // odd offset
      send_item(CMD_WRITE, counter_offset(1) | 4'h1, 16'hFFFF);
      send_item(CMD_NONE, counter_offset(0), 16'hFFFF);   // ignored entirely
      send_item(CMD_WRITE, counter_offset(0), COUNT_MAX);
      send_item(CMD_WRITE, counter_offset(3), 16'hFFFE);
      send_item(CMD_WRITE, control_offset(0), control_word(SEL_DIV1, 1'b1, 1'b1));
      send_item(CMD_WRITE, control_offset(3), 16'hFFFF);  // div 1024, spare bits set
      send_item(CMD_TICK, 4'h0, 16'h0000);                // timer 0 wraps, pulses
      send_item(CMD_READ, counter_offset(0), 16'h0000);
      send_item(CMD_WRITE, control_offset(1), control_word(SEL_DIV1, 1'b0, 1'b1));
      send_item(CMD_WRITE, counter_offset(1), COUNT_MAX);
      send_item(CMD_TICK, 4'hF, 16'hFFFF);                // timer 1 wraps quietly
      send_item(CMD_READ, counter_offset(1), 16'h0000);
      send_item(CMD_READ, control_offset(2), 16'h0000);
      send_item(CMD_WRITE, control_offset(0), 16'h0000);  // stop timer 0
      send_item(CMD_TICK, 4'h0, 16'h0000);
      send_item(CMD_READ, counter_offset(0), 16'h0000);
      send_item(CMD_READ, counter_offset(3), 16'h0000);
   endtask

   // Carry divide by 64 and 256 across counter increments, with wraps at both;
   // divide by 1024 builds up its prescale count without an increment
   task automatic test_prescaler();
      set_idling(1'b1);
      send_item(CMD_WRITE, control_offset(0), control_word(SEL_DIV1, 1'b1, 1'b1));
      send_item(CMD_WRITE, control_offset(1), control_word(SEL_DIV64, 1'b1, 1'b1));
      send_item(CMD_WRITE, control_offset(2), control_word(SEL_DIV256, 1'b1, 1'b1));
      send_item(CMD_WRITE, control_offset(3), control_word(SEL_DIV1024, 1'b1, 1'b1));
      for (int t = 1; t < BANK_TIMERS; t++)
         send_item(CMD_WRITE, counter_offset(t), COUNT_MAX);
      for (int n = 0; n < 260; n++) begin
         if (n % 97 == 0)
            send_item(CMD_READ, counter_offset(n % BANK_TIMERS), 16'h0000);
         send_item(CMD_TICK, OFFSET_W'(n), COUNT_W'(n));
      end
   endtask

   task automatic test_random_traffic(int count, bit idling);
      set_idling(idling);
      for (int n = 0; n < count; n++)
         send_random_item();
   endtask

   // Hold the response side while items keep coming, so the request side stalls
   task automatic test_backpressure();
      set_idling(1'b0);
      @(posedge clock);
      hold_start = 1'b1;
      for (int n = 0; n < 30; n++)
         send_random_item();
   endtask

   initial begin
      clear_timer_model();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_access();
      test_prescaler();
      test_random_traffic(120, 1'b1);
      test_backpressure();
      test_random_traffic(40, 1'b0);
      test_random_traffic(20, 1'b1);

      // Drop valid and let every outstanding response drain
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_timer_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_timer_rsp.size() == 0) begin
         $display("** quad_prescaled_timer_bank: PASSED **");
      end else begin
         $display("** quad_prescaled_timer_bank: FAILED **");
      end
      $finish;
   end

endmodule
